// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

	// byte codes seen on the encoded stream
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_9  = 8'h39;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LF = 8'h66;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;

	// widths and reset values
	localparam int CAP_W   = 16;
	localparam int COUNT_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = 16'd4096;

	// one raw byte request
	typedef struct packed {
		logic       start_of_body;
		logic [7:0] data_byte;
	} in_item_t;

	// one decoded result
	typedef struct packed {
		logic             out_valid;
		logic [7:0]       out_byte;
		logic [CAP_W-1:0] out_index;
		logic             overflow;
		logic             complete;
	} result_t;

endpackage

// ===== rtl/hcbd_in_stage.sv =====
module hcbd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hcbd_pkg::in_item_t in_item,
	output logic              item_valid,
	input  logic              item_ready,
	output hcbd_pkg::in_item_t item
);

	logic               valid_s1;
	hcbd_pkg::in_item_t item_s1;

	// stage is free when empty or draining this cycle
	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== rtl/hcbd_core.sv =====
module hcbd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [hcbd_pkg::CAP_W-1:0]  cfg_data,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  hcbd_pkg::in_item_t          item,
	output logic                        res_valid,
	input  logic                        res_ready,
	output hcbd_pkg::result_t           res
);

	typedef enum logic [1:0] {
		PH_SIZE    = 2'd0,
		PH_DATA    = 2'd1,
		PH_TRAILER = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	phase_t                         phase_q, ph_cur, ph_nxt;
	logic [hcbd_pkg::COUNT_W-1:0]   rem_q, rem_cur, rem_nxt;
	logic [hcbd_pkg::CAP_W-1:0]     fill_q, fill_cur, fill_nxt;
	logic [hcbd_pkg::CAP_W-1:0]     cap_q;
	logic [hcbd_pkg::CAP_W:0]       fill_inc;
	logic [4:0]                     hex;
	logic                           advance;
	logic                           fire;
	logic                           valid_s2;
	hcbd_pkg::result_t              res_s2, res_nxt;

	// bit 4 flags a hex digit, low nibble is its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= hcbd_pkg::CHAR_0 && c <= hcbd_pkg::CHAR_9) begin
				d = c - hcbd_pkg::CHAR_0;
				hex_decode = {1'b1, d[3:0]};
			end else if (c >= hcbd_pkg::CHAR_LA && c <= hcbd_pkg::CHAR_LF) begin
				d = c - hcbd_pkg::CHAR_LA + 8'd10;
				hex_decode = {1'b1, d[3:0]};
			end else if (c >= hcbd_pkg::CHAR_UA && c <= hcbd_pkg::CHAR_UF) begin
				d = c - hcbd_pkg::CHAR_UA + 8'd10;
				hex_decode = {1'b1, d[3:0]};
			end else begin
				hex_decode = 5'd0;
			end
		end
	endfunction

	// output register frees up when empty or taken
	assign advance    = !valid_s2 || res_ready;
	assign item_ready = advance;
	assign fire       = item_valid && advance;
	assign res_valid  = valid_s2;
	assign res        = res_s2;

	// decode step for one byte
	always_comb begin
		ph_cur   = item.start_of_body ? PH_SIZE : phase_q;
		rem_cur  = item.start_of_body ? '0 : rem_q;
		fill_cur = item.start_of_body ? '0 : fill_q;
		ph_nxt   = ph_cur;
		rem_nxt  = rem_cur;
		fill_nxt = fill_cur;
		hex      = hex_decode(item.data_byte);
		fill_inc = {1'b0, fill_cur} + (hcbd_pkg::CAP_W+1)'(1);
		res_nxt  = '0;
		case (ph_cur)
			PH_SIZE: begin
				if (item.data_byte == hcbd_pkg::BYTE_LF) begin
					ph_nxt = (rem_cur == '0) ? PH_DONE : PH_DATA;
				end else if (hex[4]) begin
					rem_nxt = {rem_cur[hcbd_pkg::COUNT_W-5:0], hex[3:0]};
				end
			end
			PH_DATA: begin
				if (fill_inc < {1'b0, cap_q}) begin
					res_nxt.out_valid = 1'b1;
					res_nxt.out_byte  = item.data_byte;
					res_nxt.out_index = fill_cur;
					fill_nxt          = fill_inc[hcbd_pkg::CAP_W-1:0];
				end else begin
					res_nxt.overflow = 1'b1;
				end
				rem_nxt = rem_cur - hcbd_pkg::COUNT_W'(1);
				if (rem_nxt == '0) begin
					ph_nxt = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				if (item.data_byte == hcbd_pkg::BYTE_LF) begin
					rem_nxt = '0;
					ph_nxt  = PH_SIZE;
				end
			end
			default: begin
			end
		endcase
		res_nxt.complete = (ph_nxt == PH_DONE);
	end

	// decoder state, capacity register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIZE;
			rem_q    <= '0;
			fill_q   <= '0;
			cap_q    <= hcbd_pkg::CAP_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (advance) begin
				valid_s2 <= item_valid;
			end
			if (fire) begin
				phase_q <= ph_nxt;
				rem_q   <= rem_nxt;
				fill_q  <= fill_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_nxt;
		end
	end

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Chunked transfer-encoding body decoder, one byte per cycle while m_tready is high.
// s_* stream: raw body bytes in s_tdata, s_tuser set on the first byte of a
// new body, which restarts the size parser and the fill count.
// m_* stream: one result per input byte. m_tuser marks a payload byte to be
// stored at out_index; overflow marks a payload byte dropped for lack of
// buffer space; complete is set once the terminal zero-size chunk is seen.
// cfg_* channel: writes body_capacity (buffer size with terminator slot);
// cfg_ready is always high, so write it only while no byte is in flight.
// Each request is registered in the input register and then in the output
// register before its result is offered on the m_* stream.
// Throughput: one byte per cycle while m_tready is high, as the state updates once per byte.
// Reset: capacity returns to 4096, the parser to the size phase with zero
// count and fill, and both registers empty.
// When m_tready is low the output register holds its result; the input
// register takes one more byte only if it is empty, then s_tready drops.
module http_chunked_body_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,   // body_capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // data_byte
	input  logic        s_tuser,    // start_of_body
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // out_byte[7:0], out_index[23:8], overflow[24],
	                                // complete[25], zero fill
	output logic        m_tuser     // out_valid
);

	hcbd_pkg::in_item_t in_item, item;
	hcbd_pkg::result_t  res;
	logic               item_valid;
	logic               item_ready;

	assign cfg_ready             = 1'b1;
	assign in_item.data_byte     = s_tdata;
	assign in_item.start_of_body = s_tuser;

	hcbd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	hcbd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// pack result fields onto the master stream
	assign m_tuser = res.out_valid;
	assign m_tdata = {6'd0, res.complete, res.overflow, res.out_index, res.out_byte};

endmodule

// ===== rtl/hcbd_checker.sv =====
module hcbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// stalled result holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a stored byte is never also flagged as dropped
	a_store_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[24])
		else $error("payload byte both stored and dropped");

	// payload bytes never come with completion
	a_data_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser || m_tdata[24]) |-> !m_tdata[25])
		else $error("payload byte after completion");

	// non-payload results carry zero byte and index
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[23:0] == 24'd0)
		else $error("non-payload result has data");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== verif/tb_http_chunked_body_decoder.sv =====
module tb_http_chunked_body_decoder;

	// decoder phases, as the predictor tracks them
	typedef enum logic [1:0] {
		PH_SIZE    = 2'd0,
		PH_DATA    = 2'd1,
		PH_TRAILER = 2'd2,
		PH_DONE    = 2'd3
	} dechunk_phase_t;

	// one directed request and, where typed, its result
	typedef struct packed {
		logic [7:0]        data;
		logic              start;
		logic              typed;
		hcbd_pkg::result_t want;
	} dir_row_t;

	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam int RANDOM_ITEMS   = 1900;
	localparam int PHASES         = 9;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DIR_ROWS       = 25;

	localparam hcbd_pkg::result_t QUIET = '0;
	localparam hcbd_pkg::result_t DONE_ONLY = '{out_valid: 1'b0, out_byte: 8'h00,
		out_index: 16'h0000, overflow: 1'b0, complete: 1'b1};
	localparam hcbd_pkg::result_t STORE_FF_AT_0 = '{out_valid: 1'b1, out_byte: 8'hFF,
		out_index: 16'h0000, overflow: 1'b0, complete: 1'b0};

	// size line with junk, one data byte, trailer, a count that wraps to two,
	// the terminal chunk, ignored bytes and a restart
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{8'h31,             1'b1, 1'b1, QUIET},
		'{CHAR_SEMI,         1'b0, 1'b1, QUIET},
		'{hcbd_pkg::BYTE_CR, 1'b0, 1'b1, QUIET},
		'{hcbd_pkg::BYTE_LF, 1'b0, 1'b1, QUIET},
		'{8'hFF,             1'b0, 1'b1, STORE_FF_AT_0},
		'{hcbd_pkg::BYTE_CR, 1'b0, 1'b1, QUIET},
		'{hcbd_pkg::BYTE_LF, 1'b0, 1'b1, QUIET},
		'{hcbd_pkg::CHAR_UF, 1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b0, QUIET},
		'{8'h32,             1'b0, 1'b0, QUIET},
		'{hcbd_pkg::BYTE_LF, 1'b0, 1'b0, QUIET},
		'{8'h00,             1'b0, 1'b0, QUIET},
		'{8'h80,             1'b0, 1'b0, QUIET},
		'{hcbd_pkg::BYTE_LF, 1'b0, 1'b0, QUIET},
		'{hcbd_pkg::CHAR_0,  1'b0, 1'b1, QUIET},
		'{hcbd_pkg::BYTE_LF, 1'b0, 1'b1, DONE_ONLY},
		'{8'h31,             1'b0, 1'b1, DONE_ONLY},
		'{hcbd_pkg::BYTE_LF, 1'b0, 1'b1, DONE_ONLY},
		'{8'h00,             1'b1, 1'b1, QUIET}
	};

	localparam logic [15:0] CAP_PLAN [PHASES] = '{16'd65535, 16'd1, 16'd2, 16'd24, 16'd200,
		16'd3, 16'd65535, 16'd57, 16'd1};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;    // data_byte
	logic        s_tuser   = 1'b0;  // start_of_body
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;           // out_byte, out_index, overflow, complete, zero fill
	logic        m_tuser;           // out_valid

	// directed expectation riding along with the current request
	logic              req_typed = 1'b0;
	hcbd_pkg::result_t req_want  = '0;

	// predictor state
	dechunk_phase_t phase_m     = PH_SIZE;
	logic [31:0]    remaining_m = '0;
	logic [15:0]    filled_m    = '0;
	logic [15:0]    capacity_m  = hcbd_pkg::CAP_RESET;

	hcbd_pkg::result_t pending_results [$];

	int src_gap_pct    = 0;
	int sink_stall_pct = 0;
	int errors         = 0;
	int checked        = 0;
	int stored         = 0;
	int dropped        = 0;
	int body_bytes     = 0;
	int settings_used  = 0;
	int quiet_cycles   = 0;
	bit start_pending  = 1'b0;

	http_chunked_body_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR result %0d: %s", checked, msg);
		errors++;
	endtask

	// next result of the decoder for one raw byte, advancing the predictor
	function automatic hcbd_pkg::result_t dechunk_byte(input logic [7:0] b, input logic start);
		hcbd_pkg::result_t r;
		logic              is_hex;
		logic [3:0]        nib;
		r = '0;
		is_hex = 1'b1;
		nib = '0;
		if (start) begin
			phase_m = PH_SIZE;
			remaining_m = '0;
			filled_m = '0;
		end
		case (phase_m)
			PH_SIZE: begin
				if (b == hcbd_pkg::BYTE_LF) begin
					phase_m = (remaining_m == '0) ? PH_DONE : PH_DATA;
				end else if (b != hcbd_pkg::BYTE_CR) begin
					if (b >= hcbd_pkg::CHAR_0 && b <= hcbd_pkg::CHAR_9)
						nib = 4'(b - hcbd_pkg::CHAR_0);
					else if (b >= hcbd_pkg::CHAR_LA && b <= hcbd_pkg::CHAR_LF)
						nib = 4'(b - hcbd_pkg::CHAR_LA + 8'd10);
					else if (b >= hcbd_pkg::CHAR_UA && b <= hcbd_pkg::CHAR_UF)
						nib = 4'(b - hcbd_pkg::CHAR_UA + 8'd10);
					else
						is_hex = 1'b0;
					if (is_hex)
						remaining_m = {remaining_m[27:0], nib};
				end
			end
			PH_DATA: begin
				if (int'(filled_m) + 1 < int'(capacity_m)) begin
					r.out_valid = 1'b1;
					r.out_byte = b;
					r.out_index = filled_m;
					filled_m = filled_m + 16'd1;
				end else begin
					r.overflow = 1'b1;
				end
				remaining_m = remaining_m - 32'd1;
				if (remaining_m == '0)
					phase_m = PH_TRAILER;
			end
			PH_TRAILER: begin
				if (b == hcbd_pkg::BYTE_LF) begin
					remaining_m = '0;
					phase_m = PH_SIZE;
				end
			end
			default: ;
		endcase
		r.complete = (phase_m == PH_DONE);
		return r;
	endfunction

	// receiver stalls
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// result checks, prediction on accepted requests, watchdog
	always @(posedge clk) begin
		hcbd_pkg::result_t got;
		hcbd_pkg::result_t want;
		hcbd_pkg::result_t model;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{out_valid: m_tuser, out_byte: m_tdata[7:0], out_index: m_tdata[23:8],
					overflow: m_tdata[24], complete: m_tdata[25]};
				if (pending_results.size() == 0) begin
					report_error("result with no request outstanding");
				end else begin
					want = pending_results.pop_front();
					if (got.out_valid !== want.out_valid)
						report_error($sformatf("out_valid %0b, want %0b",
							got.out_valid, want.out_valid));
					if (got.out_byte !== want.out_byte)
						report_error($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
					if (got.out_index !== want.out_index)
						report_error($sformatf("out_index %0d, want %0d",
							got.out_index, want.out_index));
					if (got.overflow !== want.overflow)
						report_error($sformatf("overflow %0b, want %0b",
							got.overflow, want.overflow));
					if (got.complete !== want.complete)
						report_error($sformatf("complete %0b, want %0b",
							got.complete, want.complete));
				end
				checked++;
			end
			if (s_tvalid && s_tready) begin
				model = dechunk_byte(s_tdata, s_tuser);
				pending_results.push_back(req_typed ? req_want : model);
				stored += model.out_valid;
				dropped += model.overflow;
			end
			if (cfg_valid && cfg_ready)
				capacity_m = cfg_data;
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// one raw byte request, with random sender gaps ahead of it
	task automatic put_byte(input logic [7:0] b, input logic start, input logic typed,
		input hcbd_pkg::result_t want);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= start;
		req_typed <= typed;
		req_want <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	// body byte, carrying the restart flag when a new body begins
	task automatic feed(input logic [7:0] b);
		put_byte(b, start_pending, 1'b0, QUIET);
		start_pending = 1'b0;
		body_bytes++;
	endtask

	task automatic put_digit(input logic [3:0] d);
		if (d < 4'd10)
			feed(8'(hcbd_pkg::CHAR_0 + d));
		else
			feed(8'(($urandom_range(1) ? hcbd_pkg::CHAR_UA : hcbd_pkg::CHAR_LA) + d - 4'd10));
	endtask

	// random byte other than LF, hex digits optional
	function automatic logic [7:0] pick_filler(input bit hex_ok);
		logic [7:0] v;
		do
			v = 8'($urandom_range(255));
		while (v == hcbd_pkg::BYTE_LF || (!hex_ok &&
			((v >= hcbd_pkg::CHAR_0 && v <= hcbd_pkg::CHAR_9)
			|| (v >= hcbd_pkg::CHAR_UA && v <= hcbd_pkg::CHAR_UF)
			|| (v >= hcbd_pkg::CHAR_LA && v <= hcbd_pkg::CHAR_LF))));
		return v;
	endfunction

	// size line tail: optional extension, optional CR, then LF
	task automatic end_size_line();
		if ($urandom_range(5) == 0) begin
			feed(CHAR_SEMI);
			repeat ($urandom_range(1, 4)) feed(pick_filler(1'b0));
		end
		if ($urandom_range(7) != 0)
			feed(hcbd_pkg::BYTE_CR);
		feed(hcbd_pkg::BYTE_LF);
	endtask

	// one encoded body, mostly well formed, sometimes cut short or oversized
	task automatic emit_body();
		int unsigned chunks;
		int unsigned len;
		int unsigned nd;
		start_pending = 1'b1;
		chunks = $urandom_range(0, 4);
		for (int c = 0; c < chunks; c++) begin
			// oversized count wraps, framing is lost until the next body
			if ($urandom_range(29) == 0) begin
				repeat ($urandom_range(9, 12)) put_digit(4'($urandom_range(15)));
				feed(hcbd_pkg::BYTE_LF);
				repeat ($urandom_range(1, 6)) feed(8'($urandom_range(255)));
				return;
			end
			len = ($urandom_range(7) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 15);
			nd = (len > 15) ? 2 : 1;
			repeat ($urandom_range(2)) put_digit(4'h0);
			for (int i = int'(nd) - 1; i >= 0; i--)
				put_digit(4'(len >> (4 * i)));
			end_size_line();
			// truncated chunk
			if ($urandom_range(15) == 0) begin
				repeat ($urandom_range(len - 1)) feed(8'($urandom_range(255)));
				return;
			end
			repeat (len) feed(8'($urandom_range(255)));
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) feed(pick_filler(1'b1));
			if ($urandom_range(7) != 0)
				feed(hcbd_pkg::BYTE_CR);
			feed(hcbd_pkg::BYTE_LF);
		end
		// terminal chunk, then bytes the decoder ignores
		repeat ($urandom_range(1, 2)) put_digit(4'h0);
		end_size_line();
		repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)), 1'b0, 1'b0, QUIET);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] cap);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// main sequence
	initial begin
		src_gap_pct = 19;
		sink_stall_pct = 74;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset capacity
		for (int r = 0; r < DIR_ROWS; r++)
			put_byte(DIRECTED[r].data, DIRECTED[r].start, DIRECTED[r].typed, DIRECTED[r].want);

		// random bodies over a range of capacities and idling patterns
		for (int p = 0; p < PHASES; p++) begin
			case (p / 3)
				0: begin
					src_gap_pct = 19;
					sink_stall_pct = 74;
				end
				1: begin
					src_gap_pct = 74;
					sink_stall_pct = 19;
				end
				default: begin
					src_gap_pct = 0;
					sink_stall_pct = 0;
				end
			endcase
			set_capacity(CAP_PLAN[p]);
			while (body_bytes < (p + 1) * RANDOM_ITEMS / PHASES) begin
				if ($urandom_range(11) == 0) begin
					// noise with random restarts
					repeat ($urandom_range(1, 15)) begin
						start_pending = ($urandom_range(3) == 0);
						feed(8'($urandom_range(255)));
					end
				end else begin
					emit_body();
				end
			end
		end

		wait_drained();
		$display("checked %0d results from %0d random body bytes over %0d capacity settings",
			checked, body_bytes, settings_used);
		$display("payload bytes stored %0d, dropped for lack of space %0d", stored, dropped);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
